### design/olie_pkg.sv
// shared types, codes and limits for the ordered list insert/erase unit
`default_nettype none

package olie_pkg;

  localparam int unsigned CapacityDefault  = 64;
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned CapacityMax      = 1024;
  localparam int unsigned IdxMaxW          = $clog2(CapacityMax);

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_READ       = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_INSERT     = 3'd1,
    CELL_ERASE      = 3'd2,
    CELL_READ_LOAD  = 3'd3,
    CELL_READ_SHIFT = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [IdxMaxW-1:0]   index;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]          command;
    logic [6:0]          position;
    logic signed [31:0]  value;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [6:0]          count;
    logic signed [31:0]  read_value;
  } rsp_t;

endpackage

`default_nettype wire

### design/olie_cell.sv
// one list slot: shifts with its neighbors and forwards read data toward slot zero
`default_nettype none

module olie_cell #(
  parameter int unsigned DATA_WIDTH = olie_pkg::DataWidthDefault,
  parameter int unsigned CELL_INDEX = 0
) (
  input  wire logic                   clk_i,
  input  wire olie_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic [DATA_WIDTH-1:0]  value_i,
  input  wire logic [DATA_WIDTH-1:0]  below_i,
  input  wire logic [DATA_WIDTH-1:0]  above_i,
  input  wire logic [DATA_WIDTH-1:0]  rd_above_i,
  output logic      [DATA_WIDTH-1:0]  data_o,
  output logic      [DATA_WIDTH-1:0]  rd_o
);

  localparam logic [olie_pkg::IdxMaxW-1:0] MyIdx = olie_pkg::IdxMaxW'(CELL_INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;

  always_comb begin
    data_d = data_q;
    rd_d   = rd_q;
    unique case (ctrl_i.op)
      olie_pkg::CELL_INSERT: begin
        if (MyIdx > ctrl_i.index) begin
          data_d = below_i;
        end else if (MyIdx == ctrl_i.index) begin
          data_d = value_i;
        end
      end
      olie_pkg::CELL_ERASE: begin
        if (MyIdx >= ctrl_i.index) begin
          data_d = above_i;
        end
      end
      olie_pkg::CELL_READ_LOAD: begin
        rd_d = (MyIdx == ctrl_i.index) ? data_q : '0;
      end
      olie_pkg::CELL_READ_SHIFT: begin
        rd_d = rd_above_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

`default_nettype wire

### design/ordered_list_insert_erase_unit.sv
// top level: command decode, count, response register and the row of list cells
//
//  channel | signals                             | payload
//  --------+-------------------------------------+---------------
//  request | in_valid_i / in_ready_o / in_req_i   | olie_pkg::req_t
//  result  | out_valid_o / out_ready_i / out_rsp_o| olie_pkg::rsp_t
//
// push, pop, insert, erase and failed commands finish in the accept cycle;
// the result is registered and shows in the next cycle.
// a read first walks the entry down the cell row, one slot a cycle.
// reset clears the count and the control state; slot contents are not reset.
// a new request is taken while idle once the result register is free or being taken.
`default_nettype none

module ordered_list_insert_erase_unit #(
  parameter int unsigned CAPACITY   = olie_pkg::CapacityDefault,
  parameter int unsigned DATA_WIDTH = olie_pkg::DataWidthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire olie_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output olie_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = ((CntW > 7) ? CntW : 7) + 1;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  olie_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      wait_q, wait_d;
  logic                 out_valid_q, out_valid_d;
  olie_pkg::rsp_t       out_q, out_d;
  olie_pkg::cell_ctrl_t ctrl;

  logic                  accept;
  logic [CmpW-1:0]       pos_w;
  logic [CmpW-1:0]       cnt_w;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  assign in_ready_o = (state_q == olie_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_w      = CmpW'(in_req_i.position);
  assign cnt_w      = CmpW'(cnt_q);
  assign full       = (cnt_q == CapCnt);
  assign empty      = (cnt_q == '0);
  assign word       = DATA_WIDTH'($unsigned(in_req_i.value));

  always_comb begin
    olie_pkg::status_e status;
    logic              start_read;
    status       = olie_pkg::STATUS_OK;
    start_read   = 1'b0;
    state_d      = state_q;
    cnt_d        = cnt_q;
    wait_d       = wait_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    ctrl.op      = olie_pkg::CELL_HOLD;
    ctrl.index   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      olie_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (olie_pkg::cmd_e'(in_req_i.command))
            olie_pkg::CMD_PUSH_FRONT, olie_pkg::CMD_PUSH_BACK, olie_pkg::CMD_INSERT: begin
              if (full) begin
                status = olie_pkg::STATUS_FULL;
              end else if (olie_pkg::cmd_e'(in_req_i.command) == olie_pkg::CMD_PUSH_FRONT) begin
                ctrl.op = olie_pkg::CELL_INSERT;
                cnt_d   = cnt_q + 1'b1;
              end else if (olie_pkg::cmd_e'(in_req_i.command) == olie_pkg::CMD_PUSH_BACK) begin
                ctrl.op    = olie_pkg::CELL_INSERT;
                ctrl.index = olie_pkg::IdxMaxW'(cnt_q);
                cnt_d      = cnt_q + 1'b1;
              end else if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
                status = olie_pkg::STATUS_RANGE;
              end else begin
                ctrl.op    = olie_pkg::CELL_INSERT;
                ctrl.index = olie_pkg::IdxMaxW'(pos_w - 1'b1);
                cnt_d      = cnt_q + 1'b1;
              end
            end
            olie_pkg::CMD_POP_FRONT, olie_pkg::CMD_POP_BACK, olie_pkg::CMD_ERASE,
            olie_pkg::CMD_READ: begin
              if (empty) begin
                status = olie_pkg::STATUS_EMPTY;
              end else if (olie_pkg::cmd_e'(in_req_i.command) == olie_pkg::CMD_POP_FRONT) begin
                ctrl.op = olie_pkg::CELL_ERASE;
                cnt_d   = cnt_q - 1'b1;
              end else if (olie_pkg::cmd_e'(in_req_i.command) == olie_pkg::CMD_POP_BACK) begin
                ctrl.op    = olie_pkg::CELL_ERASE;
                ctrl.index = olie_pkg::IdxMaxW'(cnt_q - 1'b1);
                cnt_d      = cnt_q - 1'b1;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                status = olie_pkg::STATUS_RANGE;
              end else if (olie_pkg::cmd_e'(in_req_i.command) == olie_pkg::CMD_ERASE) begin
                ctrl.op    = olie_pkg::CELL_ERASE;
                ctrl.index = olie_pkg::IdxMaxW'(pos_w - 1'b1);
                cnt_d      = cnt_q - 1'b1;
              end else begin
                ctrl.op    = olie_pkg::CELL_READ_LOAD;
                ctrl.index = olie_pkg::IdxMaxW'(pos_w - 1'b1);
                start_read = 1'b1;
                wait_d     = IdxW'(pos_w - 1'b1);
                state_d    = olie_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
          if (!start_read) begin
            out_valid_d      = 1'b1;
            out_d.status     = status;
            out_d.count      = 7'(cnt_d);
            out_d.read_value = '0;
          end
        end
      end
      olie_pkg::ST_READ: begin
        if (wait_q == '0) begin
          out_valid_d      = 1'b1;
          out_d.status     = olie_pkg::STATUS_OK;
          out_d.count      = 7'(cnt_q);
          out_d.read_value = 32'(cell_rd[0]);
          state_d          = olie_pkg::ST_IDLE;
        end else begin
          ctrl.op = olie_pkg::CELL_READ_SHIFT;
          wait_d  = wait_q - 1'b1;
        end
      end
      default: begin
        state_d = olie_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olie_pkg::ST_IDLE;
      cnt_q       <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] below;
    logic [DATA_WIDTH-1:0] above;
    logic [DATA_WIDTH-1:0] rd_above;

    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid_lo
      assign below = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign above    = '0;
      assign rd_above = '0;
    end else begin : g_mid_hi
      assign above    = cell_data[i+1];
      assign rd_above = cell_rd[i+1];
    end

    olie_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .value_i    (word),
      .below_i    (below),
      .above_i    (above),
      .rd_above_i (rd_above),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

endmodule

`default_nettype wire

### sim/olie_list_checker.sv
// checker for the ordered list unit: tracks the list, predicts each response and compares
`timescale 1ns / 1ps

module olie_list_checker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_ready_i,
  input  wire olie_pkg::req_t  in_req_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_ready_i,
  input  wire olie_pkg::rsp_t  out_rsp_i,
  output int                   mismatches_o,
  output int                   pending_o
);

  localparam int unsigned Capacity = olie_pkg::CapacityDefault;

  logic signed [31:0] list_q [Capacity];
  int unsigned        list_len;
  olie_pkg::rsp_t     expected_rsps [$];

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  function automatic olie_pkg::rsp_t apply_list_cmd(input olie_pkg::req_t r);
    olie_pkg::rsp_t rsp;
    int unsigned    slot;
    int unsigned    i;
    rsp = '0;
    rsp.status = olie_pkg::STATUS_OK;
    case (r.command)
      olie_pkg::CMD_PUSH_FRONT, olie_pkg::CMD_PUSH_BACK, olie_pkg::CMD_INSERT: begin
        if (list_len >= Capacity) begin
          rsp.status = olie_pkg::STATUS_FULL;
        end else if (r.command == olie_pkg::CMD_INSERT &&
                     (r.position < 1 || r.position > list_len + 1)) begin
          rsp.status = olie_pkg::STATUS_RANGE;
        end else begin
          if (r.command == olie_pkg::CMD_PUSH_FRONT) slot = 0;
          else if (r.command == olie_pkg::CMD_PUSH_BACK) slot = list_len;
          else slot = r.position - 1;
          for (i = list_len; i > slot; i--) list_q[i] = list_q[i - 1];
          list_q[slot] = r.value;
          list_len++;
        end
      end
      olie_pkg::CMD_POP_FRONT, olie_pkg::CMD_POP_BACK, olie_pkg::CMD_ERASE,
      olie_pkg::CMD_READ: begin
        if (list_len == 0) begin
          rsp.status = olie_pkg::STATUS_EMPTY;
        end else if ((r.command == olie_pkg::CMD_ERASE || r.command == olie_pkg::CMD_READ) &&
                     (r.position < 1 || r.position > list_len)) begin
          rsp.status = olie_pkg::STATUS_RANGE;
        end else if (r.command == olie_pkg::CMD_READ) begin
          rsp.read_value = list_q[r.position - 1];
        end else begin
          if (r.command == olie_pkg::CMD_POP_FRONT) slot = 0;
          else if (r.command == olie_pkg::CMD_POP_BACK) slot = list_len - 1;
          else slot = r.position - 1;
          for (i = slot; i + 1 < list_len; i++) list_q[i] = list_q[i + 1];
          list_len--;
          list_q[list_len] = '0;
        end
      end
      default: begin
      end
    endcase
    rsp.count = 7'(list_len);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    olie_pkg::rsp_t want;
    if (!rst_ni) begin
      list_len = 0;
      expected_rsps.delete();
      pending_o = 0;
      mismatches_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_rsp_i.status, want.status));
          if (out_rsp_i.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      out_rsp_i.count, want.count));
          if (out_rsp_i.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      out_rsp_i.read_value, want.read_value));
        end
      end
      if (in_valid_i && in_ready_i) expected_rsps.push_back(apply_list_cmd(in_req_i));
      pending_o = expected_rsps.size();
    end
  end

endmodule

### sim/tb_ordered_list_insert_erase_unit.sv
// testbench top for the ordered list unit: clock, reset, request and response traffic, verdict
`timescale 1ns / 1ps

module tb_ordered_list_insert_erase_unit;

  localparam int unsigned Capacity      = olie_pkg::CapacityDefault;
  localparam int unsigned ItemsTotal    = 1900;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 100;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_e;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  olie_pkg::req_t in_req_i;
  logic           out_valid_o;
  logic           out_ready_i;
  olie_pkg::rsp_t out_rsp_o;

  int          mismatches;
  int          pending;
  int unsigned fill;
  int unsigned sent;
  int unsigned rsp_taken;
  int unsigned cycle_cnt;
  int unsigned idle_cycles;
  logic        tx_quiet;

  always #5 clk_i = ~clk_i;

  ordered_list_insert_erase_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  olie_list_checker i_list_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_i    (out_rsp_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  function automatic int unsigned pick_gap();
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (dice < 60) return 0;
    if (dice < 90) return $urandom_range(1, 3);
    if (dice < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic olie_pkg::req_t req_of(input logic [2:0] c, input logic [6:0] p,
                                            input logic [31:0] v);
    olie_pkg::req_t r;
    r.command = c;
    r.position = p;
    r.value = v;
    return r;
  endfunction

  function automatic int unsigned count_after(input olie_pkg::req_t r, input int unsigned n);
    case (r.command)
      olie_pkg::CMD_PUSH_FRONT, olie_pkg::CMD_PUSH_BACK: return (n < Capacity) ? n + 1 : n;
      olie_pkg::CMD_INSERT:
        return (n < Capacity && r.position >= 1 && r.position <= n + 1) ? n + 1 : n;
      olie_pkg::CMD_POP_FRONT, olie_pkg::CMD_POP_BACK: return (n > 0) ? n - 1 : n;
      olie_pkg::CMD_ERASE: return (n > 0 && r.position >= 1 && r.position <= n) ? n - 1 : n;
      default: return n;
    endcase
  endfunction

  function automatic logic [6:0] pick_pos(input int unsigned lim);
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (lim == 0 || dice < 10) return 7'($urandom_range(0, 127));
    if (dice < 30) return 7'd1;
    if (dice < 50) return 7'(lim);
    return 7'($urandom_range(1, lim));
  endfunction

  function automatic olie_pkg::req_t make_req(input traffic_mode_e mode, input int unsigned n);
    olie_pkg::req_t r;
    int unsigned    dice;
    int unsigned    grow_pct;
    int unsigned    shrink_pct;
    r.position = 7'($urandom_range(0, 127));
    dice = $urandom_range(0, 9);
    case (dice)
      0: r.value = 32'h8000_0000;
      1: r.value = 32'h7fff_ffff;
      2: r.value = 32'hffff_ffff;
      3: r.value = '0;
      default: r.value = $urandom;
    endcase
    if ($urandom_range(0, 99) < 8) begin
      r.command = 3'($urandom_range(0, 7));
      return r;
    end
    case (mode)
      MODE_FILL:  begin grow_pct = 70; shrink_pct = 15; end
      MODE_DRAIN: begin grow_pct = 15; shrink_pct = 65; end
      default:    begin grow_pct = 35; shrink_pct = 35; end
    endcase
    dice = $urandom_range(0, 99);
    if (dice < grow_pct) begin
      case ($urandom_range(0, 2))
        0: r.command = olie_pkg::CMD_PUSH_FRONT;
        1: r.command = olie_pkg::CMD_PUSH_BACK;
        default: begin
          r.command = olie_pkg::CMD_INSERT;
          r.position = pick_pos(n + 1);
        end
      endcase
    end else if (dice < grow_pct + shrink_pct) begin
      case ($urandom_range(0, 2))
        0: r.command = olie_pkg::CMD_POP_FRONT;
        1: r.command = olie_pkg::CMD_POP_BACK;
        default: begin
          r.command = olie_pkg::CMD_ERASE;
          r.position = pick_pos(n);
        end
      endcase
    end else begin
      r.command = olie_pkg::CMD_READ;
      r.position = pick_pos(n);
    end
    return r;
  endfunction

  task automatic offer(input olie_pkg::req_t r);
    int unsigned gap;
    in_req_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    fill = count_after(r, fill);
    sent++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (out_valid_o && out_ready_i) rsp_taken <= rsp_taken + 1;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("ordered_list_insert_erase_unit test failed");
      $finish;
    end
  end

  initial begin : response_side
    int unsigned gap;
    int unsigned hold_at;
    out_ready_i = 1'b0;
    hold_at = 100;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_taken >= hold_at) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
        hold_at += 700;
      end else begin
        gap = ((cycle_cnt / 500) % 4 == 2) ? 0 : pick_gap();
        if (gap == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : request_side
    int unsigned   phase;
    traffic_mode_e mode;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    fill = 0;
    sent = 0;
    rsp_taken = 0;
    cycle_cnt = 0;
    idle_cycles = 0;
    tx_quiet = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty list wins over a bad position
    offer(req_of(olie_pkg::CMD_POP_FRONT, 7'd0, 32'h0));
    offer(req_of(olie_pkg::CMD_POP_BACK, 7'd0, 32'h0));
    offer(req_of(olie_pkg::CMD_ERASE, 7'd1, 32'h0));
    offer(req_of(olie_pkg::CMD_READ, 7'd127, 32'h0));
    offer(req_of(olie_pkg::CMD_INSERT, 7'd0, 32'h1234_5678));
    offer(req_of(olie_pkg::CMD_INSERT, 7'd2, 32'h1234_5678));
    offer(req_of(olie_pkg::CMD_INSERT, 7'd1, 32'h8000_0000));
    offer(req_of(olie_pkg::CMD_PUSH_FRONT, 7'd127, 32'h7fff_ffff));
    offer(req_of(olie_pkg::CMD_PUSH_BACK, 7'd0, 32'hffff_ffff));
    offer(req_of(olie_pkg::CMD_PUSH_BACK, 7'd64, 32'h0));
    offer(req_of(olie_pkg::CMD_READ, 7'd1, 32'hffff_ffff));
    offer(req_of(olie_pkg::CMD_READ, 7'd4, 32'h0));
    offer(req_of(olie_pkg::CMD_READ, 7'd5, 32'h0));
    offer(req_of(olie_pkg::CMD_READ, 7'd0, 32'h0));
    // insert at the count moves the last entry up
    offer(req_of(olie_pkg::CMD_INSERT, 7'd4, 32'h5555_5555));
    offer(req_of(olie_pkg::CMD_READ, 7'd4, 32'h0));
    offer(req_of(olie_pkg::CMD_READ, 7'd5, 32'h0));
    offer(req_of(olie_pkg::CMD_ERASE, 7'd127, 32'h0));
    offer(req_of(olie_pkg::CMD_ERASE, 7'd2, 32'h0));
    offer(req_of(3'd7, 7'd127, 32'haaaa_aaaa));
    offer(req_of(olie_pkg::CMD_POP_FRONT, 7'd0, 32'h0));
    offer(req_of(olie_pkg::CMD_POP_BACK, 7'd0, 32'h0));
    offer(req_of(olie_pkg::CMD_INSERT, 7'd3, 32'h2aaa_aaaa));
    offer(req_of(olie_pkg::CMD_READ, 7'd3, 32'h0));
    offer(req_of(olie_pkg::CMD_ERASE, 7'd1, 32'h0));

    phase = 0;
    while (sent < ItemsTotal) begin
      case (phase % 4)
        0: mode = MODE_FILL;
        2: mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      tx_quiet = ((phase % 3) == 1);
      if (mode == MODE_FILL) begin
        while (fill < Capacity) offer(make_req(mode, fill));
      end else if (mode == MODE_DRAIN) begin
        while (fill != 0) offer(make_req(mode, fill));
      end
      repeat ((mode == MODE_MIX) ? 80 : 4) offer(make_req(mode, fill));
      phase++;
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("ordered_list_insert_erase_unit test passed");
    end else begin
      $display("ordered_list_insert_erase_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/olie_pkg.sv
design/olie_cell.sv
design/ordered_list_insert_erase_unit.sv
sim/olie_list_checker.sv
sim/tb_ordered_list_insert_erase_unit.sv
